[design/emm_pkg.sv]
// Shared types and constants for the expanded memory page mapper.
// Depends on nothing; every other design file imports it.
package emm_pkg;

  localparam int CMD_W   = 4;
  localparam int HID_W   = 8;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 8;
  localparam int STAT_W  = 4;

  localparam int FRAMES  = 4;
  localparam int FIDX_W  = 2;

  localparam logic [PAGE_W-1:0] NOT_MAPPED  = 16'hFFFF;
  localparam logic [PAGE_W-1:0] RESET_TOTAL = 16'd2048;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_DEALLOC = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MAP     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_UNMAP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SAVE    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_HPAGES  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_HCOUNT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FREE    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_FQUERY  = 4'd9;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK           = 4'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_REQ     = 4'd1;
  localparam logic [STAT_W-1:0] ST_NO_TOTAL     = 4'd2;
  localparam logic [STAT_W-1:0] ST_NO_FREE      = 4'd3;
  localparam logic [STAT_W-1:0] ST_HANDLES_FULL = 4'd4;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE   = 4'd5;
  localparam logic [STAT_W-1:0] ST_LOGICAL      = 4'd6;
  localparam logic [STAT_W-1:0] ST_FRAME        = 4'd7;
  localparam logic [STAT_W-1:0] ST_SAVE_OWNED   = 4'd8;
  localparam logic [STAT_W-1:0] ST_SAVE_FULL    = 4'd9;
  localparam logic [STAT_W-1:0] ST_NOT_OWNED    = 4'd10;
  localparam logic [STAT_W-1:0] ST_RESTORE_FAIL = 4'd11;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] value;
    logic [HID_W-1:0]  handle_out;
    logic [PAGE_W-1:0] total_out;
  } emm_res_t;

endpackage

[design/emm_if.sv]
// Request and result channel interfaces of the expanded memory page mapper.
// Depends on emm_pkg for the field widths.
interface emm_in_if import emm_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [HID_W-1:0]   handle_id;
  logic [PAGE_W-1:0]  request_pages;
  logic [PAGE_W-1:0]  logical_page;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, command, handle_id, request_pages, logical_page, frame,
                  input ready);
  modport sink   (input valid, command, handle_id, request_pages, logical_page, frame,
                  output ready);
endinterface

interface emm_out_if import emm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] value;
  logic [HID_W-1:0]  handle_out;
  logic [PAGE_W-1:0] total_out;

  modport source (output valid, status, value, handle_out, total_out, input ready);
  modport sink   (input valid, status, value, handle_out, total_out, output ready);
endinterface

[design/emm_page_ram.sv]
// Handle page-count memory: one write port, one read port, registered read.
// Depends on emm_pkg for the page width.
module emm_page_ram import emm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [PAGE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [PAGE_W-1:0] rdata
);

  logic [PAGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/emm_ctrl.sv]
// Command sequencer: handle valid bits, free pool, frame map and save area.
// Depends on emm_pkg, emm_if and emm_page_ram (per-handle page counts).
module emm_ctrl import emm_pkg::*; #(
  parameter int HANDLES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              init_we,
  input  logic [PAGE_W-1:0] init_total,
  input  logic [PAGE_W-1:0] total,
  emm_in_if.sink            in_ch,
  input  logic              slot_free,
  output logic              done,
  output emm_res_t          res
);

  localparam int HW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int CW = $clog2(HANDLES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_REST_RD, S_REST_CHK, S_DONE
  } state_t;

  state_t              state_r;
  logic [HANDLES-1:0]  in_use_r;
  logic [CW-1:0]       cnt_r;
  logic [PAGE_W-1:0]   free_r;
  logic [HID_W-1:0]    fown_r  [FRAMES];
  logic [PAGE_W-1:0]   fpage_r [FRAMES];
  logic [HID_W-1:0]    sowner_r;
  logic [HID_W-1:0]    sown_r  [FRAMES];
  logic [PAGE_W-1:0]   spage_r [FRAMES];

  logic [CMD_W-1:0]    cmd_r;
  logic [HID_W-1:0]    h_r;
  logic [PAGE_W-1:0]   req_r;
  logic [PAGE_W-1:0]   lp_r;
  logic [FRAME_W-1:0]  fr_r;
  logic [HW-1:0]       scan_r;
  logic [FIDX_W-1:0]   fi_r;
  emm_res_t            res_r;

  logic [HW-1:0]       h_idx;
  logic                h_ok;
  logic                fr_ok;
  logic [FIDX_W-1:0]   fr_idx;
  logic [HW-1:0]       rown_idx;
  logic                rown_ok;
  logic                save_empty;
  logic [PAGE_W:0]     ret_sum;

  logic                ram_we;
  logic [HW-1:0]       ram_raddr;
  logic [PAGE_W-1:0]   ram_rdata;

  assign h_idx    = h_r[HW-1:0];
  assign h_ok     = (32'(h_r) < HANDLES) && in_use_r[h_idx];
  assign fr_ok    = 32'(fr_r) < FRAMES;
  assign fr_idx   = fr_r[FIDX_W-1:0];
  assign rown_idx = sown_r[fi_r][HW-1:0];
  assign rown_ok  = (32'(sown_r[fi_r]) < HANDLES) && in_use_r[rown_idx];
  assign ret_sum  = {1'b0, free_r} + {1'b0, ram_rdata};

  always_comb begin
    save_empty = 1'b1;
    for (int i = 0; i < FRAMES; i++) begin
      if (spage_r[i] != NOT_MAPPED) begin
        save_empty = 1'b0;
      end
    end
  end

  // The count is read the cycle a request is taken so it is ready in S_EXEC;
  // during restore the owner of the frame under test is read instead.
  // The only write happens in S_SCAN, which never overlaps a pending read.
  assign ram_raddr = (state_r == S_IDLE) ? in_ch.handle_id[HW-1:0] : rown_idx;
  assign ram_we    = (state_r == S_SCAN) && !in_use_r[scan_r];

  emm_page_ram #(.DEPTH(HANDLES), .AW(HW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_r),
    .wdata (req_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign done        = (state_r == S_DONE) && slot_free;
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n || init_we) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      cnt_r    <= '0;
      free_r   <= rst_n ? init_total : RESET_TOTAL;
      sowner_r <= HID_W'(HANDLES);
      for (int i = 0; i < FRAMES; i++) begin
        fown_r[i]  <= '0;
        fpage_r[i] <= NOT_MAPPED;
        sown_r[i]  <= '0;
        spage_r[i] <= NOT_MAPPED;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.command;
            h_r     <= in_ch.handle_id;
            req_r   <= in_ch.request_pages;
            lp_r    <= in_ch.logical_page;
            fr_r    <= in_ch.frame;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r   <= '0;
          state_r <= S_DONE;
          unique case (cmd_r)
            CMD_ALLOC: begin
              if (req_r == '0) begin
                res_r.status <= ST_ZERO_REQ;
              end else if (req_r > free_r) begin
                res_r.status <= (req_r > total) ? ST_NO_TOTAL : ST_NO_FREE;
              end else begin
                scan_r  <= '0;
                state_r <= S_SCAN;
              end
            end
            CMD_DEALLOC: begin
              if (!h_ok) begin
                res_r.status <= ST_BAD_HANDLE;
              end else begin
                free_r          <= ret_sum[PAGE_W] ? NOT_MAPPED : ret_sum[PAGE_W-1:0];
                in_use_r[h_idx] <= 1'b0;
                cnt_r           <= cnt_r - 1'b1;
                for (int i = 0; i < FRAMES; i++) begin
                  if (fown_r[i] == h_r) begin
                    fpage_r[i] <= NOT_MAPPED;
                  end
                end
              end
            end
            CMD_MAP: begin
              if (!h_ok) begin
                res_r.status <= ST_BAD_HANDLE;
              end else if (lp_r >= ram_rdata) begin
                res_r.status <= ST_LOGICAL;
              end else if (!fr_ok) begin
                res_r.status <= ST_FRAME;
              end else begin
                fown_r[fr_idx]  <= h_r;
                fpage_r[fr_idx] <= lp_r;
              end
            end
            CMD_UNMAP: begin
              if (!fr_ok) begin
                res_r.status <= ST_FRAME;
              end else begin
                fown_r[fr_idx]  <= '0;
                fpage_r[fr_idx] <= NOT_MAPPED;
              end
            end
            CMD_SAVE: begin
              if (!h_ok) begin
                res_r.status <= ST_BAD_HANDLE;
              end else if (!save_empty) begin
                res_r.status <= (sowner_r == h_r) ? ST_SAVE_OWNED : ST_SAVE_FULL;
              end else begin
                sowner_r <= h_r;
                for (int i = 0; i < FRAMES; i++) begin
                  sown_r[i]  <= fown_r[i];
                  spage_r[i] <= fpage_r[i];
                end
              end
            end
            CMD_RESTORE: begin
              if (!h_ok) begin
                res_r.status <= ST_BAD_HANDLE;
              end else if (sowner_r != h_r) begin
                res_r.status <= ST_NOT_OWNED;
              end else begin
                fi_r    <= '0;
                state_r <= S_REST_RD;
              end
            end
            CMD_HPAGES: begin
              if (!h_ok) begin
                res_r.status <= ST_BAD_HANDLE;
              end else begin
                res_r.value <= ram_rdata;
              end
            end
            CMD_HCOUNT: begin
              res_r.value <= PAGE_W'(cnt_r);
            end
            CMD_FREE: begin
              res_r.value     <= free_r;
              res_r.total_out <= total;
            end
            CMD_FQUERY: begin
              if (!fr_ok) begin
                res_r.status <= ST_FRAME;
              end else begin
                res_r.value      <= fpage_r[fr_idx];
                res_r.handle_out <= fown_r[fr_idx];
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          // One handle per cycle, lowest index first.
          if (!in_use_r[scan_r]) begin
            in_use_r[scan_r] <= 1'b1;
            cnt_r            <= cnt_r + 1'b1;
            free_r           <= free_r - req_r;
            res_r.handle_out <= HID_W'(scan_r);
            state_r          <= S_DONE;
          end else if (32'(scan_r) == HANDLES - 1) begin
            res_r.status <= ST_HANDLES_FULL;
            state_r      <= S_DONE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_REST_RD: begin
          state_r <= S_REST_CHK;
        end
        S_REST_CHK: begin
          if (spage_r[fi_r] != NOT_MAPPED && !(rown_ok && spage_r[fi_r] < ram_rdata)) begin
            // Frames already restored stay changed and the save area is kept.
            res_r.status <= ST_RESTORE_FAIL;
            state_r      <= S_DONE;
          end else begin
            if (spage_r[fi_r] == NOT_MAPPED) begin
              fown_r[fi_r]  <= '0;
              fpage_r[fi_r] <= NOT_MAPPED;
            end else begin
              fown_r[fi_r]  <= sown_r[fi_r];
              fpage_r[fi_r] <= spage_r[fi_r];
            end
            if (32'(fi_r) == FRAMES - 1) begin
              sowner_r <= HID_W'(HANDLES);
              for (int i = 0; i < FRAMES; i++) begin
                spage_r[i] <= NOT_MAPPED;
              end
              state_r <= S_DONE;
            end else begin
              fi_r    <= fi_r + 1'b1;
              state_r <= S_REST_RD;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/expanded_memory_page_mapper.sv]
// Expanded memory page mapper in the style of an EMS 4.0 manager.
// Each request on in_ch is one command (allocate, deallocate, map, unmap,
// save, restore or a query); each gives exactly one result on out_ch with
// a status code and data fields that are zero on any error.
// cfg_we with cfg_wdata sets total_pages and returns the whole pool, the
// handle table, the frame map and the save area to their reset state;
// write it only while no request is in flight.
// For most commands a request passes from acceptance through the execute
// state to the done state, which hands the result to the output register,
// and the next request is taken once the sequencer is back in idle.
// Allocate walks the handle valid bits one per cycle; restore reads the
// page-count memory once per frame, through a read state and a check
// state for each frame. One request is worked at a time.
// The result sits in an output register, so a new request is taken while
// a finished result still waits; if the receiver stalls with the register
// full, the next result waits in the sequencer and in_ch.ready stays low.
// Reset (rst_n low, synchronous) clears all valid bits and sets
// total_pages to 2048; the page-count memory needs no clearing pass.
// Depends on emm_pkg, emm_if, emm_ctrl and emm_page_ram.
module expanded_memory_page_mapper import emm_pkg::*; #(
  parameter int HANDLES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata,
  emm_in_if.sink            in_ch,
  emm_out_if.source         out_ch
);

  logic [PAGE_W-1:0] total_r;
  logic              out_valid_r;
  emm_res_t          out_data_r;
  logic              slot_free;
  logic              done;
  emm_res_t          res;

  assign slot_free = !out_valid_r || out_ch.ready;

  emm_ctrl #(.HANDLES(HANDLES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_we    (cfg_we),
    .init_total (cfg_wdata),
    .total      (total_r),
    .in_ch      (in_ch),
    .slot_free  (slot_free),
    .done       (done),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= RESET_TOTAL;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      if (done) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.value      = out_data_r.value;
  assign out_ch.handle_out = out_data_r.handle_out;
  assign out_ch.total_out  = out_data_r.total_out;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for expanded_memory_page_mapper: a directed command table,
// then random command streams under several pool sizes, checked against table results or a predictor.
// Depends on emm_pkg and the emm_in_if / emm_out_if interfaces.
module tb_top;
  import emm_pkg::*;

  localparam int NUM_HANDLES = 16;
  localparam int PHASE_ITEMS = 95;
  localparam logic [CMD_W-1:0] CMD_TOP = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [HID_W-1:0]   hid;
    logic [PAGE_W-1:0]  req_pages;
    logic [PAGE_W-1:0]  lpage;
    logic [FRAME_W-1:0] frame;
  } emm_cmd_t;

  typedef struct packed {
    emm_cmd_t item;
    bit       typed;
    emm_res_t res;
  } table_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [PAGE_W-1:0] cfg_wdata;

  emm_in_if  in_ch ();
  emm_out_if out_ch ();

  expanded_memory_page_mapper #(.HANDLES(NUM_HANDLES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Mirror of the mapper's bookkeeping.
  logic [PAGE_W-1:0]  pool_total;
  logic [PAGE_W-1:0]  pool_free;
  bit                 hnd_used   [NUM_HANDLES];
  logic [PAGE_W-1:0]  hnd_pages  [NUM_HANDLES];
  logic [HID_W-1:0]   frm_owner  [FRAMES];
  logic [PAGE_W-1:0]  frm_page   [FRAMES];
  logic [HID_W-1:0]   sav_owner;
  logic [HID_W-1:0]   sav_fowner [FRAMES];
  logic [PAGE_W-1:0]  sav_page   [FRAMES];

  emm_res_t   pending_res [$];
  table_row_t cmd_table [$];
  int         mismatch_cnt = 0;
  int         result_cnt = 0;
  bit         quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_pool(input logic [PAGE_W-1:0] total);
    pool_total = total;
    pool_free  = total;
    for (int i = 0; i < NUM_HANDLES; i++) begin
      hnd_used[i]  = 1'b0;
      hnd_pages[i] = '0;
    end
    for (int i = 0; i < FRAMES; i++) begin
      frm_owner[i]  = '0;
      frm_page[i]   = NOT_MAPPED;
      sav_fowner[i] = '0;
      sav_page[i]   = NOT_MAPPED;
    end
    sav_owner = HID_W'(NUM_HANDLES);
  endfunction

  function automatic bit handle_live(input logic [HID_W-1:0] h);
    return (h < NUM_HANDLES) && hnd_used[h];
  endfunction

  function automatic logic [STAT_W-1:0] try_map(input logic [HID_W-1:0] h,
                                                input logic [PAGE_W-1:0] pg,
                                                input logic [FRAME_W-1:0] fr);
    if (!handle_live(h)) return ST_BAD_HANDLE;
    if (pg >= hnd_pages[h]) return ST_LOGICAL;
    if (fr >= FRAMES) return ST_FRAME;
    frm_owner[fr[FIDX_W-1:0]] = h;
    frm_page[fr[FIDX_W-1:0]]  = pg;
    return ST_OK;
  endfunction

  // Applies one command to the mirrored state and returns the result it gives.
  function automatic emm_res_t predict_result(input emm_cmd_t c);
    emm_res_t         r;
    logic [PAGE_W:0]  sum;
    bit               found;
    bit               empty;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_ALLOC: begin
        if (c.req_pages == 0) begin
          r.status = ST_ZERO_REQ;
        end else if (c.req_pages > pool_free) begin
          r.status = (c.req_pages > pool_total) ? ST_NO_TOTAL : ST_NO_FREE;
        end else begin
          found = 1'b0;
          for (int i = 0; i < NUM_HANDLES; i++) begin
            if (!found && !hnd_used[i]) begin
              found        = 1'b1;
              hnd_used[i]  = 1'b1;
              hnd_pages[i] = c.req_pages;
              pool_free    = pool_free - c.req_pages;
              r.handle_out = HID_W'(i);
            end
          end
          if (!found) r.status = ST_HANDLES_FULL;
        end
      end
      CMD_DEALLOC: begin
        if (!handle_live(c.hid)) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          sum = {1'b0, pool_free} + {1'b0, hnd_pages[c.hid]};
          pool_free = sum[PAGE_W] ? NOT_MAPPED : sum[PAGE_W-1:0];
          hnd_used[c.hid]  = 1'b0;
          hnd_pages[c.hid] = '0;
          // Frames keep their owner; only the page is dropped.
          for (int i = 0; i < FRAMES; i++)
            if (frm_owner[i] == c.hid) frm_page[i] = NOT_MAPPED;
        end
      end
      CMD_MAP: r.status = try_map(c.hid, c.lpage, c.frame);
      CMD_UNMAP: begin
        if (c.frame >= FRAMES) begin
          r.status = ST_FRAME;
        end else begin
          frm_owner[c.frame[FIDX_W-1:0]] = '0;
          frm_page[c.frame[FIDX_W-1:0]]  = NOT_MAPPED;
        end
      end
      CMD_SAVE: begin
        if (!handle_live(c.hid)) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          empty = 1'b1;
          for (int i = 0; i < FRAMES; i++)
            if (sav_page[i] != NOT_MAPPED) empty = 1'b0;
          if (!empty) begin
            r.status = (sav_owner == c.hid) ? ST_SAVE_OWNED : ST_SAVE_FULL;
          end else begin
            sav_owner = c.hid;
            for (int i = 0; i < FRAMES; i++) begin
              sav_fowner[i] = frm_owner[i];
              sav_page[i]   = frm_page[i];
            end
          end
        end
      end
      CMD_RESTORE: begin
        if (!handle_live(c.hid)) r.status = ST_BAD_HANDLE;
        else if (sav_owner != c.hid) r.status = ST_NOT_OWNED;
        // Frames are rebuilt in order; the first one that fails to map stops the walk.
        for (int i = 0; i < FRAMES; i++) begin
          if (r.status == ST_OK) begin
            if (sav_page[i] == NOT_MAPPED) begin
              frm_owner[i] = '0;
              frm_page[i]  = NOT_MAPPED;
            end else if (try_map(sav_fowner[i], sav_page[i], FRAME_W'(i)) != ST_OK) begin
              r.status = ST_RESTORE_FAIL;
            end
          end
        end
        if (r.status == ST_OK) begin
          sav_owner = HID_W'(NUM_HANDLES);
          for (int i = 0; i < FRAMES; i++) sav_page[i] = NOT_MAPPED;
        end
      end
      CMD_HPAGES: begin
        if (!handle_live(c.hid)) r.status = ST_BAD_HANDLE;
        else r.value = hnd_pages[c.hid];
      end
      CMD_HCOUNT: begin
        for (int i = 0; i < NUM_HANDLES; i++)
          if (hnd_used[i]) r.value = r.value + 1'b1;
      end
      CMD_FREE: begin
        r.value     = pool_free;
        r.total_out = pool_total;
      end
      CMD_FQUERY: begin
        if (c.frame >= FRAMES) begin
          r.status = ST_FRAME;
        end else begin
          r.value      = frm_page[c.frame[FIDX_W-1:0]];
          r.handle_out = frm_owner[c.frame[FIDX_W-1:0]];
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) begin
      r.value      = '0;
      r.handle_out = '0;
      r.total_out  = '0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Mostly a live handle, sometimes any table slot, now and then any 8-bit value.
  function automatic logic [HID_W-1:0] pick_handle();
    int live [$];
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return HID_W'($urandom);
    for (int i = 0; i < NUM_HANDLES; i++)
      if (hnd_used[i]) live.push_back(i);
    if (r == 1 || live.size() == 0) return HID_W'($urandom_range(0, NUM_HANDLES - 1));
    return HID_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    if ($urandom_range(0, 6) == 0) return FRAME_W'($urandom);
    return FRAME_W'($urandom_range(0, FRAMES - 1));
  endfunction

  // Fields a command does not use keep their random values.
  function automatic emm_cmd_t random_cmd();
    emm_cmd_t          c;
    int                r;
    int                span;
    logic [PAGE_W-1:0] cnt;
    c.cmd       = CMD_W'($urandom);
    c.hid       = HID_W'($urandom);
    c.req_pages = PAGE_W'($urandom);
    c.lpage     = PAGE_W'($urandom);
    c.frame     = FRAME_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      c.cmd = CMD_ALLOC;
      span = $urandom_range(0, 19);
      if (span < 12) c.req_pages = PAGE_W'($urandom_range(1, 1 + pool_total / 32));
      else if (span < 15) c.req_pages = (pool_free != 0) ? pool_free : PAGE_W'(1);
      else if (span < 17) c.req_pages = PAGE_W'($urandom_range(1, pool_total));
      else if (span == 17) c.req_pages = '0;
    end else if (r < 28) begin
      c.cmd = CMD_DEALLOC;
      c.hid = pick_handle();
    end else if (r < 48) begin
      c.cmd = CMD_MAP;
      c.hid = pick_handle();
      cnt = (c.hid < NUM_HANDLES) ? hnd_pages[c.hid] : '0;
      span = $urandom_range(0, 9);
      if (span < 8) c.lpage = (cnt != 0) ? PAGE_W'($urandom_range(0, cnt - 1)) : '0;
      else if (span == 8) c.lpage = cnt;
      c.frame = pick_frame();
    end else if (r < 55) begin
      c.cmd = CMD_UNMAP;
      c.frame = pick_frame();
    end else if (r < 63) begin
      c.cmd = CMD_SAVE;
      c.hid = pick_handle();
    end else if (r < 71) begin
      c.cmd = CMD_RESTORE;
      if (sav_owner < NUM_HANDLES && $urandom_range(0, 1) == 1) c.hid = sav_owner;
      else c.hid = pick_handle();
    end else if (r < 77) begin
      c.cmd = CMD_HPAGES;
      c.hid = pick_handle();
    end else if (r < 82) begin
      c.cmd = CMD_HCOUNT;
    end else if (r < 87) begin
      c.cmd = CMD_FREE;
    end else if (r < 95) begin
      c.cmd = CMD_FQUERY;
      c.frame = pick_frame();
    end else begin
      c.cmd = CMD_W'($urandom_range(CMD_FQUERY + 1, CMD_TOP));
    end
    return c;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("%0t: result %0d: %s", $time, result_cnt, msg);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [HID_W-1:0] h,
                         input logic [PAGE_W-1:0] rq, input logic [PAGE_W-1:0] lp,
                         input logic [FRAME_W-1:0] fr, input bit typed,
                         input logic [STAT_W-1:0] st, input logic [PAGE_W-1:0] val,
                         input logic [HID_W-1:0] ho, input logic [PAGE_W-1:0] tot);
    table_row_t row;
    row.item.cmd       = cmd;
    row.item.hid       = h;
    row.item.req_pages = rq;
    row.item.lpage     = lp;
    row.item.frame     = fr;
    row.typed          = typed;
    row.res.status     = st;
    row.res.value      = val;
    row.res.handle_out = ho;
    row.res.total_out  = tot;
    cmd_table.push_back(row);
  endtask

  // One request per call; the expectation is queued when the request is taken.
  task automatic put_request(input emm_cmd_t c, input bit typed, input emm_res_t want);
    int       gap;
    emm_res_t model;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command       <= c.cmd;
    in_ch.handle_id     <= c.hid;
    in_ch.request_pages <= c.req_pages;
    in_ch.logical_page  <= c.lpage;
    in_ch.frame         <= c.frame;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model = predict_result(c);
    pending_res.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  task automatic write_total(input logic [PAGE_W-1:0] total);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= total;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clear_pool(total);
  endtask

  initial begin
    int                drain_at;
    logic [PAGE_W-1:0] pool_sizes [$];
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.handle_id     = '0;
    in_ch.request_pages = '0;
    in_ch.logical_page  = '0;
    in_ch.frame         = '0;
    clear_pool(RESET_TOTAL);

    add_row(CMD_FREE,    8'd0,   16'd0,    16'd0,    8'd0,   1, ST_OK, RESET_TOTAL, 8'd0,
            RESET_TOTAL);
    add_row(CMD_HCOUNT,  8'd0,   16'd0,    16'd0,    8'd0,   1, ST_OK, 16'd0, 8'd0, 16'd0);
    add_row(CMD_ALLOC,   8'd0,   16'd0,    16'd0,    8'd0,   1, ST_ZERO_REQ, 0, 0, 0);
    add_row(CMD_ALLOC,   8'd0,   16'hFFFF, 16'd0,    8'd0,   1, ST_NO_TOTAL, 0, 0, 0);
    add_row(CMD_ALLOC,   8'd0,   16'd2048, 16'd0,    8'd0,   1, ST_OK, 16'd0, 8'd0, 16'd0);
    add_row(CMD_ALLOC,   8'd0,   16'd1,    16'd0,    8'd0,   1, ST_NO_FREE, 0, 0, 0);
    add_row(CMD_HPAGES,  8'd0,   16'd0,    16'd0,    8'd0,   1, ST_OK, 16'd2048, 8'd0, 16'd0);
    add_row(CMD_HPAGES,  8'hFF,  16'd0,    16'd0,    8'd0,   1, ST_BAD_HANDLE, 0, 0, 0);
    // Logical page equal to the handle's page count is out of range.
    add_row(CMD_MAP,     8'd0,   16'd0,    16'd2048, 8'd0,   1, ST_LOGICAL, 0, 0, 0);
    add_row(CMD_MAP,     8'd0,   16'd0,    16'd2047, 8'hFF,  1, ST_FRAME, 0, 0, 0);
    add_row(CMD_MAP,     8'd0,   16'd0,    16'd2047, 8'd3,   0, ST_OK, 0, 0, 0);
    add_row(CMD_MAP,     8'd0,   16'd0,    16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_FQUERY,  8'd0,   16'd0,    16'd0,    8'd3,   0, ST_OK, 0, 0, 0);
    add_row(CMD_FQUERY,  8'd0,   16'd0,    16'd0,    8'hFF,  1, ST_FRAME, 0, 0, 0);
    add_row(CMD_SAVE,    8'd0,   16'd0,    16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_SAVE,    8'd0,   16'd0,    16'd0,    8'd0,   1, ST_SAVE_OWNED, 0, 0, 0);
    add_row(CMD_UNMAP,   8'hFF,  16'hFFFF, 16'hFFFF, 8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_UNMAP,   8'd0,   16'd0,    16'd0,    8'd4,   1, ST_FRAME, 0, 0, 0);
    add_row(CMD_RESTORE, 8'd1,   16'd0,    16'd0,    8'd0,   1, ST_BAD_HANDLE, 0, 0, 0);
    add_row(CMD_DEALLOC, 8'd0,   16'd0,    16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC,   8'd0,   16'd10,   16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC,   8'd0,   16'd5,    16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_SAVE,    8'd1,   16'd0,    16'd0,    8'd0,   1, ST_SAVE_FULL, 0, 0, 0);
    add_row(CMD_RESTORE, 8'd1,   16'd0,    16'd0,    8'd0,   1, ST_NOT_OWNED, 0, 0, 0);
    // The saved page 2047 no longer fits the reallocated handle, so restore stops.
    add_row(CMD_RESTORE, 8'd0,   16'd0,    16'd0,    8'd0,   0, ST_OK, 0, 0, 0);
    add_row(CMD_TOP,     8'hFF,  16'hFFFF, 16'hFFFF, 8'hFF,  1, ST_OK, 16'd0, 8'd0, 16'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (cmd_table[i]) put_request(cmd_table[i].item, cmd_table[i].typed, cmd_table[i].res);

    pool_sizes = '{16'd1, 16'hFFFF, 16'd40, 16'd300, PAGE_W'($urandom_range(1, 65535))};
    foreach (pool_sizes[p]) begin
      drain_at = $urandom_range(30, PHASE_ITEMS - 5);
      drain_results();
      write_total(pool_sizes[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (n < 20);
        if (n == drain_at) drain_results();
        put_request(random_cmd(), 1'b0, '0);
      end
      quiet = 1'b0;
    end

    drain_results();
    repeat (2 * NUM_HANDLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    emm_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_res.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = pending_res.pop_front();
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.value !== want.value)
          flag_mismatch($sformatf("value %0d, expected %0d", out_ch.value, want.value));
        if (out_ch.handle_out !== want.handle_out)
          flag_mismatch($sformatf("handle_out %0d, expected %0d", out_ch.handle_out,
                                  want.handle_out));
        if (out_ch.total_out !== want.total_out)
          flag_mismatch($sformatf("total_out %0d, expected %0d", out_ch.total_out,
                                  want.total_out));
      end
      result_cnt++;
    end
  end

endmodule
